@@ sv/spq_pkg.sv @@
// Shared constants and types for the sorted insertion priority queue.
package spq_pkg;

  localparam int unsigned DEPTH    = 16;
  localparam int unsigned KEY_BITS = 32;
  localparam int unsigned TAG_BITS = 16;
  localparam int unsigned CNT_BITS = $clog2(DEPTH + 1);

  localparam logic REQ_INSERT  = 1'b0;
  localparam logic REQ_DEQUEUE = 1'b1;

  // Command broadcast to every cell of the chain.
  typedef struct packed {
    logic                do_ins;
    logic                do_deq;
    logic [KEY_BITS-1:0] key;
    logic [TAG_BITS-1:0] tag;
  } spq_cmd_t;

endpackage

@@ sv/spq_cell.sv @@
// One storage cell of the sorted chain: holds one key and tag pair.
module spq_cell (
  input  logic                           clk,
  input  spq_pkg::spq_cmd_t              cmd,
  input  logic                           occ,
  input  logic                           left_ins,
  input  logic [spq_pkg::KEY_BITS-1:0]   left_key,
  input  logic [spq_pkg::TAG_BITS-1:0]   left_tag,
  input  logic [spq_pkg::KEY_BITS-1:0]   right_key,
  input  logic [spq_pkg::TAG_BITS-1:0]   right_tag,
  output logic                           ins,
  output logic [spq_pkg::KEY_BITS-1:0]   key,
  output logic [spq_pkg::TAG_BITS-1:0]   tag
);

  // An empty cell counts as "not below" so the new entry lands at the tail.
  assign ins = !occ || (cmd.key <= key);

  always_ff @(posedge clk) begin
    if (cmd.do_ins) begin
      if (left_ins) begin
        // Insertion point lies to the left: shift up.
        key <= left_key;
        tag <= left_tag;
      end else if (ins) begin
        key <= cmd.key;
        tag <= cmd.tag;
      end
    end else if (cmd.do_deq) begin
      key <= right_key;
      tag <= right_tag;
    end
  end

endmodule

@@ sv/sorted_insert_priority_queue_core.sv @@
// Top level of the sorted insertion priority queue: cell chain, count and result register.
//
// Usage:
//   Request channel: drive req_type, entry_key and entry_tag and raise start.
//   A request beat is taken at every rising edge with start high and busy low.
//   busy stays low: the chain takes one request every cycle.
//   req_type REQ_INSERT places the pair ahead of the first stored key that is
//   greater than or equal to the new key; REQ_DEQUEUE pops the smallest key.
//   Result channel: one result beat per request, shown for exactly one cycle
//   with done high, in the cycle after the request edge (throughput
//   1 request per cycle). The receiver cannot stall; a result is gone after
//   its cycle.
//   Every cell compares its key with the broadcast key in the same cycle and
//   shifts to its neighbor, so insert and dequeue each take a single compare
//   per cell and a one-entry shift.
//   An insert into a full queue is dropped and flagged by insert_refused.
//   A dequeue on an empty queue returns out_valid low with key and tag zero.
//   Reset (rst, synchronous) empties the queue and drops any pending result;
//   cell contents are left as they are and only cells below the count are read.
module sorted_insert_priority_queue_core (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  output logic                           busy,
  input  logic                           req_type,
  input  logic [spq_pkg::KEY_BITS-1:0]   entry_key,
  input  logic [spq_pkg::TAG_BITS-1:0]   entry_tag,
  output logic                           done,
  output logic                           out_valid,
  output logic [spq_pkg::KEY_BITS-1:0]   out_key,
  output logic [spq_pkg::TAG_BITS-1:0]   out_tag,
  output logic [spq_pkg::CNT_BITS-1:0]   entry_count,
  output logic                           insert_refused
);

  localparam int unsigned CW = spq_pkg::CNT_BITS;
  localparam logic [CW-1:0] FULL = CW'(spq_pkg::DEPTH);

  logic [CW-1:0] count;
  logic [CW-1:0] count_next;
  logic          accept;
  logic          is_full;
  logic          is_empty;

  spq_pkg::spq_cmd_t cmd;

  logic                         cell_occ [spq_pkg::DEPTH];
  logic                         cell_ins [spq_pkg::DEPTH];
  logic [spq_pkg::KEY_BITS-1:0] cell_key [spq_pkg::DEPTH];
  logic [spq_pkg::TAG_BITS-1:0] cell_tag [spq_pkg::DEPTH];

  // The chain never holds a request back.
  assign busy   = 1'b0;
  assign accept = start && !busy;

  assign is_full  = (count == FULL);
  assign is_empty = (count == '0);

  // Broadcast the beat to every cell; drop inserts when full, pops when empty.
  always_comb begin
    cmd.do_ins = accept && (req_type == spq_pkg::REQ_INSERT) && !is_full;
    cmd.do_deq = accept && (req_type == spq_pkg::REQ_DEQUEUE) && !is_empty;
    cmd.key    = entry_key;
    cmd.tag    = entry_tag;
  end

  always_comb begin
    count_next = count;
    if (cmd.do_ins) begin
      count_next = count + CW'(1);
    end else if (cmd.do_deq) begin
      count_next = count - CW'(1);
    end
  end

  // Build the chain: each cell sees its left neighbor's insert flag and data
  // for shifting up, and its right neighbor's data for shifting down.
  genvar gi;
  for (gi = 0; gi < spq_pkg::DEPTH; gi++) begin : g_cell
    logic                         l_ins;
    logic [spq_pkg::KEY_BITS-1:0] l_key;
    logic [spq_pkg::TAG_BITS-1:0] l_tag;
    logic [spq_pkg::KEY_BITS-1:0] r_key;
    logic [spq_pkg::TAG_BITS-1:0] r_tag;

    assign cell_occ[gi] = (count > CW'(gi));

    if (gi == 0) begin : g_head
      assign l_ins = 1'b0;
      assign l_key = entry_key;
      assign l_tag = entry_tag;
    end else begin : g_body
      assign l_ins = cell_ins[gi-1];
      assign l_key = cell_key[gi-1];
      assign l_tag = cell_tag[gi-1];
    end

    if (gi == spq_pkg::DEPTH - 1) begin : g_tail
      // Hold the last cell on a pop; it falls outside the count anyway.
      assign r_key = cell_key[gi];
      assign r_tag = cell_tag[gi];
    end else begin : g_mid
      assign r_key = cell_key[gi+1];
      assign r_tag = cell_tag[gi+1];
    end

    spq_cell u_cell (
      .clk       (clk),
      .cmd       (cmd),
      .occ       (cell_occ[gi]),
      .left_ins  (l_ins),
      .left_key  (l_key),
      .left_tag  (l_tag),
      .right_key (r_key),
      .right_tag (r_tag),
      .ins       (cell_ins[gi]),
      .key       (cell_key[gi]),
      .tag       (cell_tag[gi])
    );
  end

  // Control state: count and result strobe.
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      done  <= 1'b0;
    end else begin
      count <= count_next;
      done  <= accept;
    end
  end

  // Result payload on each accepted beat: the head on a pop, zeros otherwise, plus count and refuse flag.
  always_ff @(posedge clk) begin
    if (accept) begin
      out_valid      <= cmd.do_deq;
      out_key        <= cmd.do_deq ? cell_key[0] : '0;
      out_tag        <= cmd.do_deq ? cell_tag[0] : '0;
      entry_count    <= count_next;
      insert_refused <= (req_type == spq_pkg::REQ_INSERT) && is_full;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= FULL)
    else $error("entry count above depth");

  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    accept |=> done)
    else $error("request beat without result beat");

  a_refused_full: assert property (@(posedge clk) disable iff (rst)
    done && insert_refused |-> entry_count == FULL)
    else $error("insert refused while not full");

  a_valid_excl: assert property (@(posedge clk) disable iff (rst)
    done && out_valid |-> !insert_refused && entry_count < FULL)
    else $error("pop result carries refuse flag or full count");

  a_head_sorted: assert property (@(posedge clk) disable iff (rst)
    count > CW'(1) |-> cell_key[0] <= cell_key[1])
    else $error("head key above its neighbor");

endmodule

@@ bench/tb.sv @@
// Self-checking bench for the sorted insertion priority queue core.
`timescale 1ns / 100ps

module tb;

  // Run bounds: directed beats come first, then about this many random ones.
  localparam int unsigned RANDOM_REQS = 1600;
  localparam int unsigned CYCLE_LIMIT = 200_000;

  // One request beat as it is driven onto the ports.
  typedef struct packed {
    logic                         op;
    logic [spq_pkg::KEY_BITS-1:0] key;
    logic [spq_pkg::TAG_BITS-1:0] tag;
  } pq_req_t;

  // One result beat as the core should report it.
  typedef struct packed {
    logic                         valid;
    logic [spq_pkg::KEY_BITS-1:0] key;
    logic [spq_pkg::TAG_BITS-1:0] tag;
    logic [spq_pkg::CNT_BITS-1:0] count;
    logic                         refused;
  } pq_res_t;

  logic                         clk = 1'b0;
  logic                         rst = 1'b1;
  logic                         start = 1'b0;
  logic                         req_type = spq_pkg::REQ_INSERT;
  logic [spq_pkg::KEY_BITS-1:0] entry_key = '0;
  logic [spq_pkg::TAG_BITS-1:0] entry_tag = '0;
  logic                         busy;
  logic                         done;
  logic                         out_valid;
  logic [spq_pkg::KEY_BITS-1:0] out_key;
  logic [spq_pkg::TAG_BITS-1:0] out_tag;
  logic [spq_pkg::CNT_BITS-1:0] entry_count;
  logic                         insert_refused;

  // Requests still to be driven, and results the core still owes us.
  pq_req_t queued_requests[$];
  pq_res_t pending_outcomes[$];

  // Shadow copy of the sorted store: ascending keys, newest first among equals.
  logic [spq_pkg::KEY_BITS-1:0] shadow_key[spq_pkg::DEPTH];
  logic [spq_pkg::TAG_BITS-1:0] shadow_tag[spq_pkg::DEPTH];
  int unsigned                  shadow_fill = 0;

  // Driver pacing: cycles to hold off before the next beat, and a
  // back-to-back mode that gives stretches with no gaps at all.
  int unsigned hold_off = 0;
  bit          back_to_back = 1'b0;
  pq_req_t     cur_req;

  int unsigned n_fail = 0;
  int unsigned n_inserts = 0;
  int unsigned n_refused = 0;
  int unsigned n_dequeues = 0;
  int unsigned n_empty_pops = 0;
  int unsigned n_checked = 0;
  int unsigned peak_fill = 0;
  int unsigned cycle_cnt = 0;

  sorted_insert_priority_queue_core DUT (
    .clk            (clk),
    .rst            (rst),
    .start          (start),
    .busy           (busy),
    .req_type       (req_type),
    .entry_key      (entry_key),
    .entry_tag      (entry_tag),
    .done           (done),
    .out_valid      (out_valid),
    .out_key        (out_key),
    .out_tag        (out_tag),
    .entry_count    (entry_count),
    .insert_refused (insert_refused)
  );

  always #5 clk = ~clk;

  // Apply one accepted request to the shadow store and queue the result it
  // should produce.
  function automatic void apply_to_shadow_queue(input pq_req_t rq);
    pq_res_t     res;
    int unsigned slot;
    res = '0;
    if (rq.op == spq_pkg::REQ_INSERT) begin
      n_inserts++;
      if (shadow_fill >= spq_pkg::DEPTH) begin
        // Full: drop the entry, leave the store alone, flag the refusal.
        res.refused = 1'b1;
        n_refused++;
      end else begin
        // Land ahead of the first stored key that is not below the new one.
        slot = shadow_fill;
        for (int i = 0; i < shadow_fill; i++) begin
          if (slot == shadow_fill && rq.key <= shadow_key[i]) slot = i;
        end
        for (int i = shadow_fill; i > slot; i--) begin
          shadow_key[i] = shadow_key[i-1];
          shadow_tag[i] = shadow_tag[i-1];
        end
        shadow_key[slot] = rq.key;
        shadow_tag[slot] = rq.tag;
        shadow_fill++;
        if (shadow_fill > peak_fill) peak_fill = shadow_fill;
      end
    end else begin
      n_dequeues++;
      if (shadow_fill == 0) begin
        // Empty pop: everything reads zero.
        n_empty_pops++;
      end else begin
        // Pop the head and close the gap.
        res.valid = 1'b1;
        res.key   = shadow_key[0];
        res.tag   = shadow_tag[0];
        for (int i = 1; i < shadow_fill; i++) begin
          shadow_key[i-1] = shadow_key[i];
          shadow_tag[i-1] = shadow_tag[i];
        end
        shadow_fill--;
      end
    end
    res.count = shadow_fill[spq_pkg::CNT_BITS-1:0];
    pending_outcomes.insert(pending_outcomes.size(), res);
  endfunction

  task automatic add_req(input logic op, input logic [spq_pkg::KEY_BITS-1:0] key,
                         input logic [spq_pkg::TAG_BITS-1:0] tag);
    pq_req_t rq;
    rq.op  = op;
    rq.key = key;
    rq.tag = tag;
    queued_requests.insert(queued_requests.size(), rq);
  endtask

  // Driver: at each edge, log the beat the core just took, then present the
  // next one or hold start low for the drawn gap.
  always @(posedge clk) begin
    if (rst) begin
      start       <= 1'b0;
      shadow_fill = 0;
      hold_off    = 0;
    end else begin
      if (start && !busy) apply_to_shadow_queue(cur_req);
      if (!start || !busy) begin
        if (hold_off > 0) begin
          hold_off--;
          start <= 1'b0;
        end else if (queued_requests.size() != 0) begin
          cur_req = queued_requests.pop_front();
          req_type  <= cur_req.op;
          entry_key <= cur_req.key;
          entry_tag <= cur_req.tag;
          start     <= 1'b1;
          // Flip between gappy and back-to-back pacing now and then.
          if ($urandom_range(0, 39) == 0) back_to_back = !back_to_back;
          hold_off = back_to_back ? 0 : $urandom_range(0, 7);
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // Monitor: every done beat must match the oldest outstanding expectation.
  always @(posedge clk) begin
    pq_res_t want;
    if (!rst && done) begin
      if (pending_outcomes.size() == 0) begin
        $error("result beat with no request outstanding");
        n_fail++;
      end else begin
        want = pending_outcomes.pop_front();
        n_checked++;
        if (out_valid !== want.valid) begin
          $error("out_valid: expected %0b, got %0b", want.valid, out_valid);
          n_fail++;
        end
        if (out_key !== want.key) begin
          $error("out_key: expected %h, got %h", want.key, out_key);
          n_fail++;
        end
        if (out_tag !== want.tag) begin
          $error("out_tag: expected %h, got %h", want.tag, out_tag);
          n_fail++;
        end
        if (entry_count !== want.count) begin
          $error("entry_count: expected %0d, got %0d", want.count, entry_count);
          n_fail++;
        end
        if (insert_refused !== want.refused) begin
          $error("insert_refused: expected %0b, got %0b", want.refused, insert_refused);
          n_fail++;
        end
      end
    end
  end

  // Watchdog: abort a hung run.
  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("tb: errors");
      $finish;
    end
  end

  initial begin
    int unsigned                  n_rand;
    int unsigned                  run_len;
    int unsigned                  ins_pct;
    int unsigned                  rnd;
    logic                         op;
    logic [spq_pkg::KEY_BITS-1:0] key;
    logic [spq_pkg::TAG_BITS-1:0] tag;
    n_rand = 0;

    // Directed opening: pop on empty with all-ones in the ignored fields.
    add_req(spq_pkg::REQ_DEQUEUE, '1, '1);
    // Key extremes, then three equal keys: the newest must come out first.
    add_req(spq_pkg::REQ_INSERT, '1, '1);
    add_req(spq_pkg::REQ_INSERT, '0, '0);
    add_req(spq_pkg::REQ_INSERT, 32'd5, 16'h000A);
    add_req(spq_pkg::REQ_INSERT, 32'd5, 16'h000B);
    add_req(spq_pkg::REQ_INSERT, 32'd5, 16'h000C);
    // Equal to the stored max key: goes ahead of it.
    add_req(spq_pkg::REQ_INSERT, '1, 16'h0001);
    repeat (3) add_req(spq_pkg::REQ_DEQUEUE, '0, '0);
    // Fill to the brim with falling keys; each one lands just behind the stored key 5.
    for (int i = 0; i < 13; i++) begin
      add_req(spq_pkg::REQ_INSERT, 32'h8000_0000 >> i, i[spq_pkg::TAG_BITS-1:0]);
    end
    // Full: this one would take the head but must be refused.
    add_req(spq_pkg::REQ_INSERT, '0, '1);
    add_req(spq_pkg::REQ_DEQUEUE, '0, '0);

    // Random runs: fill-heavy, drain-heavy and mixed stretches so the queue
    // keeps swinging between empty and full.
    while (n_rand < RANDOM_REQS) begin
      case ($urandom_range(0, 3))
        0:       ins_pct = 85;
        1:       ins_pct = 15;
        default: ins_pct = 50;
      endcase
      run_len = $urandom_range(8, 48);
      for (int j = 0; j < run_len; j++) begin
        op = ($urandom_range(0, 99) < ins_pct) ? spq_pkg::REQ_INSERT : spq_pkg::REQ_DEQUEUE;
        case ($urandom_range(0, 9))
          0:       key = '0;
          1:       key = '1;
          2, 3:    key = $urandom_range(0, 7);  // tight pool forces ties
          default: key = $urandom;
        endcase
        rnd = $urandom;
        tag = rnd[spq_pkg::TAG_BITS-1:0];
        add_req(op, key, tag);
        n_rand++;
      end
    end

    // Hold reset, then release.
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // Wait for every beat to go in and every result to come back.
    while (queued_requests.size() != 0 || start) @(posedge clk);
    while (pending_outcomes.size() != 0) @(posedge clk);
    repeat (5) @(posedge clk);

    if (pending_outcomes.size() != 0) begin
      $error("%0d results never arrived", pending_outcomes.size());
      n_fail++;
    end

    $display("summary: %0d results checked; %0d inserts (%0d refused when full), %0d dequeues",
             n_checked, n_inserts, n_refused, n_dequeues);
    $display("summary: %0d dequeues on empty, peak fill %0d of %0d, %0d failures",
             n_empty_pops, peak_fill, spq_pkg::DEPTH, n_fail);
    if (n_fail == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end

endmodule
